FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/mbb_pkg.sv
`default_nettype none

package mbb_pkg;

	localparam int AXES       = 3;
	localparam int FIELD_W    = 32;
	localparam int IN_DATA_W  = AXES * FIELD_W;
	localparam int OUT_WORDS  = 10;
	localparam int OUT_DATA_W = OUT_WORDS * FIELD_W;

	typedef struct packed {
		logic fold;
		logic clear;
	} bnd_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mbb_bounds.sv
`default_nettype none

`include "assert_macros.svh"

module mbb_bounds #(
	parameter int CW = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mbb_pkg::bnd_ctrl_t      ctrl,
	input  logic signed [CW-1:0]    pos  [mbb_pkg::AXES],
	output logic                    seen,
	output logic signed [CW-1:0]    low  [mbb_pkg::AXES],
	output logic signed [CW-1:0]    high [mbb_pkg::AXES]
);

	logic                 seen_q;
	logic signed [CW-1:0] low_q  [mbb_pkg::AXES];
	logic signed [CW-1:0] high_q [mbb_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			for (int a = 0; a < mbb_pkg::AXES; a++) begin
				low_q[a]  <= '0;
				high_q[a] <= '0;
			end
		end else if (ctrl.clear) begin
			seen_q <= 1'b0;
			for (int a = 0; a < mbb_pkg::AXES; a++) begin
				low_q[a]  <= '0;
				high_q[a] <= '0;
			end
		end else if (ctrl.fold) begin
			seen_q <= 1'b1;
			for (int a = 0; a < mbb_pkg::AXES; a++) begin
				if (!seen_q || pos[a] < low_q[a]) begin
					low_q[a] <= pos[a];
				end
				if (!seen_q || pos[a] > high_q[a]) begin
					high_q[a] <= pos[a];
				end
			end
		end
	end

	assign seen = seen_q;
	assign low  = low_q;
	assign high = high_q;

	`MBB_ASSERT_IMP(a_box_ordered, clk, arst_n, seen_q,
		low_q[0] <= high_q[0] && low_q[1] <= high_q[1] && low_q[2] <= high_q[2])

endmodule

`default_nettype wire

FILE: rtl/mbb_isqrt.sv
`default_nettype none

`include "assert_macros.svh"

module mbb_isqrt #(
	parameter int RW = 33
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  logic                    start,
	input  logic [2*RW-1:0]         radicand,
	output logic [RW-1:0]           root,
	output mbb_pkg::sqrt_stat_t     stat
);

	localparam int CNT_W = $clog2(RW + 1);

	logic [2*RW-1:0]  rad_q;
	logic [RW:0]      rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW+2:0]    cur;
	logic [RW+2:0]    sub;
	logic [RW+2:0]    diff;
	logic             fits;

	always_comb begin
		cur  = {rem_q, rad_q[2*RW-1 -: 2]};
		sub  = (RW+3)'({root_q, 2'b01});
		fits = (cur >= sub);
		diff = cur - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(RW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? diff[RW:0] : cur[RW:0];
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign root        = root_q;
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;

	`MBB_ASSERT_IMP(a_start_when_idle, clk, arst_n, start, !busy_q)

endmodule

`default_nettype wire

FILE: rtl/mesh_bounding_box.sv
// Axis-aligned bounding box and bounding-sphere radius of a vertex stream.
// Input requests carry one vertex (x, y, z in signed fixed point) in s_tdata, a
// has-vertex flag in s_tuser and the end of a mesh in s_tlast. A request
// without tlast leaves the block ready again at once, so vertices stream at
// one per clock. A request with tlast starts the result
// sequence: three squarings on one shared multiplier, then a restoring square
// root that retires one root bit per cycle, COORD_WIDTH + 1 steps in all. The
// result is loaded into the output register once the root is done and the
// register is free; s_tready stays low until then. A result waits there
// for m_tready; a new mesh may stream in meanwhile, and only its own end
// waits for the output register to free. The result carries the box, the
// centre and the radius in m_tdata, and the empty flag in m_tuser, which is
// set, with all data zero, when the mesh had no vertex. Reset clears the box
// and the sequencer, and drops m_tvalid.
`default_nettype none

`include "assert_macros.svh"

module mesh_bounding_box #(
	parameter int COORD_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// pos_x, pos_y, pos_z
	input  wire  [mbb_pkg::IN_DATA_W-1:0]     s_tdata,
	// has_vertex
	input  wire                               s_tuser,
	input  wire                               s_tlast,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, center_x, center_y, center_z, radius
	output logic [mbb_pkg::OUT_DATA_W-1:0]    m_tdata,
	// empty_res
	output logic                              m_tuser
);

	localparam int CW = COORD_WIDTH;
	localparam int RW = CW + 1;
	localparam int FW = mbb_pkg::FIELD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GO,
		ST_ROOT,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic [1:0]             ax_q;
	logic                   prod_vld_s1;
	logic [2*CW-1:0]        prod_s1;
	logic [2*RW-1:0]        sum_q;
	logic [FW-1:0]          data_q [mbb_pkg::OUT_WORDS];
	logic                   empty_q;

	logic signed [CW-1:0]   pos  [mbb_pkg::AXES];
	logic signed [CW-1:0]   low  [mbb_pkg::AXES];
	logic signed [CW-1:0]   high [mbb_pkg::AXES];
	logic                   seen;
	logic [CW-1:0]          ext  [mbb_pkg::AXES];
	logic signed [CW:0]     diff [mbb_pkg::AXES];
	logic signed [CW:0]     csum [mbb_pkg::AXES];
	logic [CW-1:0]          mul_op;
	logic [RW-1:0]          root;
	logic [63:0]            rad_wide;
	logic [FW-1:0]          res  [mbb_pkg::OUT_WORDS];

	mbb_pkg::bnd_ctrl_t     bnd_ctrl;
	mbb_pkg::sqrt_stat_t    sq_stat;
	logic                   accept;
	logic                   load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load     = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	assign bnd_ctrl.fold  = accept && s_tuser;
	assign bnd_ctrl.clear = load;

	always_comb begin
		for (int a = 0; a < mbb_pkg::AXES; a++) begin
			pos[a]  = s_tdata[FW*a +: CW];
			diff[a] = (CW+1)'(high[a]) - (CW+1)'(low[a]);
			ext[a]  = diff[a][CW-1:0];
			csum[a] = (CW+1)'(high[a]) + (CW+1)'(low[a]);
		end
	end

	always_comb begin
		case (ax_q)
			2'd0:    mul_op = ext[0];
			2'd1:    mul_op = ext[1];
			2'd2:    mul_op = ext[2];
			default: mul_op = '0;
		endcase
	end

	mbb_bounds #(
		.CW(CW)
	) u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bnd_ctrl),
		.pos    (pos),
		.seen   (seen),
		.low    (low),
		.high   (high)
	);

	mbb_isqrt #(
		.RW(RW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_GO),
		.radicand (sum_q),
		.root     (root),
		.stat     (sq_stat)
	);

	always_comb begin
		rad_wide = 64'(root >> 1);
		for (int a = 0; a < mbb_pkg::AXES; a++) begin
			res[a]     = FW'(low[a]);
			res[3 + a] = FW'(high[a]);
			res[6 + a] = FW'(csum[a] >>> 1);
		end
		res[9] = rad_wide[FW-1:0];
		if (!seen) begin
			for (int w = 0; w < mbb_pkg::OUT_WORDS; w++) begin
				res[w] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			prod_vld_s1 <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ax_q        <= '0;
					prod_vld_s1 <= 1'b0;
					if (accept && s_tlast) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					ax_q        <= ax_q + 1'b1;
					prod_vld_s1 <= (ax_q != 2'd3);
					if (ax_q == 2'd3) begin
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					prod_vld_s1 <= 1'b0;
					state_q     <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sq_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (2*CW)'(mul_op) * (2*CW)'(mul_op);
		if (accept && s_tlast) begin
			sum_q <= '0;
		end else if (prod_vld_s1) begin
			sum_q <= sum_q + (2*RW)'(prod_s1);
		end
		if (load) begin
			data_q  <= res;
			empty_q <= !seen;
		end
	end

	always_comb begin
		for (int w = 0; w < mbb_pkg::OUT_WORDS; w++) begin
			m_tdata[FW*w +: FW] = data_q[w];
		end
	end

	assign m_tuser = empty_q;

	`MBB_ASSERT_IMP(a_empty_is_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	`MBB_ASSERT_NXT(a_last_starts_seq, clk, arst_n, accept && s_tlast, state_q == ST_MUL)
	`MBB_ASSERT_IMP(a_root_only_in_seq, clk, arst_n, sq_stat.busy, state_q == ST_ROOT)

endmodule

`default_nettype wire
